FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the hand grab and pinch tracker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/core/hgpet_pkg.sv
// Types and constants of the hand grab and pinch event tracker.
`timescale 1ns / 1ps

package hgpet_pkg;

	localparam int STRENGTH_W = 11;
	localparam int COUNT_W    = 4;
	localparam int ID_W       = 32;
	localparam int FINGER_W   = 3;
	localparam int TOUCH_W    = 12;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_GRAB_THRESHOLD  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PINCH_THRESHOLD = 1'd1;

	// Reset values: 1024 is 1.0, 819 is 0.8.
	localparam logic [STRENGTH_W-1:0] GRAB_THRESHOLD_RST  = 11'd1024;
	localparam logic [STRENGTH_W-1:0] PINCH_THRESHOLD_RST = 11'd819;

	// Edge codes of grab_edge and pinch_edge.
	localparam logic [1:0] EDGE_NONE     = 2'd0;
	localparam logic [1:0] EDGE_PRESSED  = 2'd1;
	localparam logic [1:0] EDGE_RELEASED = 2'd2;

	// Item modes.
	localparam logic MODE_FRAME = 1'b0;
	localparam logic MODE_HAND  = 1'b1;

	typedef struct packed {
		logic                        mode;
		logic [COUNT_W-1:0]          hand_count;
		logic signed [ID_W-1:0]      hand_id;
		logic                        hand_is_left;
		logic [STRENGTH_W-1:0]       grab_strength;
		logic [STRENGTH_W-1:0]       pinch_strength;
		logic [FINGER_W-1:0]         finger_count;
		logic signed [TOUCH_W-1:0]   touch_distance;
	} hgpet_in_t;

	typedef struct packed {
		logic       grabbing;
		logic [1:0] grab_edge;
		logic       pinching;
		logic [1:0] pinch_edge;
		logic       finger_count_changed;
		logic       front_touch;
		logic       side_left;
		logic       hand_count_changed;
		logic       release_axes;
		logic       table_full;
	} hgpet_out_t;

	// Stored state of one tracked hand.
	typedef struct packed {
		logic                grabbed;
		logic                pinched;
		logic [FINGER_W-1:0] fingers;
	} hand_state_t;

	localparam int STATE_W = $bits(hand_state_t);

	// Result of the id lookup in the hand table.
	typedef struct packed {
		hand_state_t past;
		logic        full;
	} lookup_t;

	// Write request into the hand table.
	typedef struct packed {
		logic        en;
		hand_state_t state;
	} table_wr_t;

endpackage

FILE: rtl/core/hgpet_table.sv
// Hand table: per-id state with parallel id match, allocation and update.
`timescale 1ns / 1ps

module hgpet_table #(
	parameter int MAX_HANDS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic signed [hgpet_pkg::ID_W-1:0] lookup_id,
	input  hgpet_pkg::table_wr_t          wr,
	output hgpet_pkg::lookup_t            lkp
);
	import hgpet_pkg::*;

	logic [MAX_HANDS-1:0]   valid_q;
	logic [ID_W-1:0]        key_q   [MAX_HANDS];
	hand_state_t            state_q [MAX_HANDS];

	logic [MAX_HANDS-1:0]   hit_oh;
	logic [MAX_HANDS-1:0]   free_oh;
	logic [MAX_HANDS-1:0]   sel_oh;
	logic                   hit_found;
	logic                   free_found;
	logic [STATE_W-1:0]     past_bits;

	// First matching valid entry, and first free entry for a new id.
	always_comb begin
		hit_oh     = '0;
		free_oh    = '0;
		hit_found  = 1'b0;
		free_found = 1'b0;
		past_bits  = '0;
		for (int i = 0; i < MAX_HANDS; i++) begin
			if (valid_q[i]) begin
				if (!hit_found && key_q[i] == lookup_id) begin
					hit_oh[i] = 1'b1;
					hit_found = 1'b1;
				end
			end else if (!free_found) begin
				free_oh[i] = 1'b1;
				free_found = 1'b1;
			end
		end
		for (int i = 0; i < MAX_HANDS; i++) begin
			past_bits = past_bits | (state_q[i] & {STATE_W{hit_oh[i]}});
		end
		sel_oh    = hit_found ? hit_oh : free_oh;
		lkp.past  = hand_state_t'(past_bits);
		lkp.full  = !hit_found && !free_found;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q <= valid_q | sel_oh;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_HANDS; i++) begin
			if (wr.en && sel_oh[i]) begin
				key_q[i]   <= lookup_id;
				state_q[i] <= wr.state;
			end
		end
	end

endmodule

FILE: rtl/core/hgpet_eval.sv
// Result logic: grab and pinch levels and edges, finger, touch and count flags.
`timescale 1ns / 1ps

module hgpet_eval (
	input  hgpet_pkg::hgpet_in_t                   item,
	input  hgpet_pkg::lookup_t                     lkp,
	input  logic [hgpet_pkg::STRENGTH_W-1:0]       grab_th,
	input  logic [hgpet_pkg::STRENGTH_W-1:0]       pinch_th,
	input  logic [hgpet_pkg::COUNT_W-1:0]          last_count,
	output hgpet_pkg::hgpet_out_t                  result,
	output hgpet_pkg::hand_state_t                 new_state
);
	import hgpet_pkg::*;

	logic grabbed;
	logic pinch_now;
	logic pinched;
	logic count_changed;

	always_comb begin
		grabbed       = item.grab_strength >= grab_th;
		pinch_now     = item.pinch_strength > pinch_th;
		// Pinch keeps its stored value while the hand is closed.
		pinched       = grabbed ? lkp.past.pinched : pinch_now;
		count_changed = item.hand_count != last_count;

		new_state.grabbed = grabbed;
		new_state.pinched = pinched;
		new_state.fingers = item.finger_count;

		result = '0;
		if (item.mode == MODE_FRAME) begin
			result.hand_count_changed = count_changed;
			result.release_axes       = count_changed && (item.hand_count == '0);
		end else begin
			result.grabbing = grabbed;
			if (grabbed && !lkp.past.grabbed) begin
				result.grab_edge = EDGE_PRESSED;
			end else if (!grabbed && lkp.past.grabbed) begin
				result.grab_edge = EDGE_RELEASED;
			end else begin
				result.grab_edge = EDGE_NONE;
			end
			if (!grabbed) begin
				result.pinching = pinched;
				if (pinched && !lkp.past.pinched) begin
					result.pinch_edge = EDGE_PRESSED;
				end else if (!pinched && lkp.past.pinched) begin
					result.pinch_edge = EDGE_RELEASED;
				end else begin
					result.pinch_edge = EDGE_NONE;
				end
			end
			result.finger_count_changed = item.finger_count != lkp.past.fingers;
			result.front_touch = (item.touch_distance == '0) ||
				item.touch_distance[TOUCH_W-1];
			result.side_left  = item.hand_is_left;
			result.table_full = lkp.full;
		end
	end

endmodule

FILE: rtl/core/hand_grab_pinch_event_tracker.sv
// Top level of the hand grab and pinch event tracker.
`timescale 1ns / 1ps
// Usage:
// The input channel (in_valid, in_ready, in_data) takes frame-start items,
// which carry the hand count, and hand observations. Every transfer in yields
// exactly one result transfer on the output channel (out_valid, out_ready,
// out_data), in order.
// An accepted item sits in the input register, where its id is compared against
// all table entries in parallel; the result is written into the output register
// when that register frees up, together with the table update. One item per
// cycle is sustained while the receiver does not stall: the table is updated at
// the same edge at which the following item starts its lookup, so back-to-back
// items on one id are exact.
// If the receiver stalls, the output register holds its result and the input
// register holds one more item; in_ready falls only when both are full.
// Reset clears both pipeline valids, empties the hand table, zeroes the last
// hand count and loads the threshold reset values (1024 for grab, 819 for
// pinch). Thresholds are written through cfg_we/cfg_index/cfg_wdata while the
// block is idle.

module hand_grab_pinch_event_tracker #(
	parameter int MAX_HANDS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  hgpet_pkg::hgpet_in_t                in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output hgpet_pkg::hgpet_out_t               out_data,
	input  logic                                cfg_we,
	input  logic [hgpet_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [hgpet_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import hgpet_pkg::*;

	`include "assert_macros.svh"

	logic                  valid_s1;
	hgpet_in_t             item_s1;
	logic                  out_valid_q;
	hgpet_out_t            out_q;
	logic [STRENGTH_W-1:0] grab_th_q;
	logic [STRENGTH_W-1:0] pinch_th_q;
	logic [COUNT_W-1:0]    last_count_q;

	logic                  advance;
	logic                  commit;
	lookup_t               lkp;
	table_wr_t             wr;
	hgpet_out_t            result;
	hand_state_t           new_state;

	// The output register frees up when empty or when its result is taken;
	// the input register then moves its item on in the same cycle.
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign commit   = valid_s1 && advance;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Only observations touch the table; a full table leaves it unchanged.
	assign wr.en    = commit && (item_s1.mode == MODE_HAND);
	assign wr.state = new_state;

	hgpet_table #(
		.MAX_HANDS(MAX_HANDS)
	) u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.lookup_id (item_s1.hand_id),
		.wr        (wr),
		.lkp       (lkp)
	);

	hgpet_eval u_eval (
		.item       (item_s1),
		.lkp        (lkp),
		.grab_th    (grab_th_q),
		.pinch_th   (pinch_th_q),
		.last_count (last_count_q),
		.result     (result),
		.new_state  (new_state)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			out_valid_q  <= 1'b0;
			last_count_q <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
			if (commit && item_s1.mode == MODE_FRAME) begin
				last_count_q <= item_s1.hand_count;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
		if (commit) begin
			out_q <= result;
		end
	end

	// Threshold registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grab_th_q  <= GRAB_THRESHOLD_RST;
			pinch_th_q <= PINCH_THRESHOLD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GRAB_THRESHOLD: begin
					grab_th_q <= cfg_wdata;
				end
				REG_PINCH_THRESHOLD: begin
					pinch_th_q <= cfg_wdata;
				end
				default: begin
				end
			endcase
		end
	end

	// Assertions.
	`ASSERT_NEVER(a_pinch_while_grab, out_valid_q && out_q.grabbing && out_q.pinching, "pinching reported while grabbing")
	`ASSERT_CLK(a_release_needs_change, out_valid_q && out_q.release_axes |-> out_q.hand_count_changed && !out_q.grabbing && !out_q.table_full, "axis release without a hand count change")
	`ASSERT_CLK(a_full_is_cleared, valid_s1 && lkp.full |-> lkp.past == '0, "full table lookup returned stored state")
	`ASSERT_CLK(a_count_update, commit && item_s1.mode == MODE_FRAME |=> last_count_q == $past(item_s1.hand_count), "last hand count not updated by frame start")

endmodule

FILE: dv/tb.sv
// Self-checking testbench of the hand grab and pinch event tracker.
`timescale 1ns / 1ps

// The bench drives frame starts and hand observations into the tracker over
// the input valid/ready channel. It predicts every result with its own model
// of the hand table, the last hand count and the two thresholds, then checks
// each output transfer field by field against the oldest pending prediction.
// The run opens with a few directed items: hand-count changes and the release
// of the axes, ids at the extremes of the 32-bit range, a full table, and the
// grab/pinch edges with pinch frozen while grabbing. A stretch of receiver
// back-pressure follows. Then come random frames, each followed by its hand
// observations, mixed with stray items, under several threshold settings and
// three idling profiles.

module tb;
	import hgpet_pkg::*;

	localparam int TABLE_DEPTH    = 8;
	localparam int STALL_LIMIT    = 4000;
	localparam int HOLD_CYCLES    = 300;
	localparam int DRAIN_CYCLES   = 8;
	localparam int MAX_GAP        = 30;
	localparam int MAX_PRINTED    = 60;
	localparam int BLOCK_ITEMS    = 150;
	localparam int BLOCKS_PER_RUN = 4;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	hgpet_in_t             in_data   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	hgpet_out_t            out_data;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_GRAB_THRESHOLD;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	// Predicted state of the block: the hand table, the last frame's hand
	// count and the threshold registers.
	logic                  tracked_valid   [TABLE_DEPTH];
	logic [ID_W-1:0]       tracked_id      [TABLE_DEPTH];
	logic                  tracked_grabbed [TABLE_DEPTH];
	logic                  tracked_pinched [TABLE_DEPTH];
	logic [FINGER_W-1:0]   tracked_fingers [TABLE_DEPTH];
	logic [COUNT_W-1:0]    prev_hand_count;
	logic [STRENGTH_W-1:0] grab_thr;
	logic [STRENGTH_W-1:0] pinch_thr;

	// Results predicted for accepted items, oldest first.
	hgpet_out_t expected_results[$];

	int error_count   = 0;
	int src_idle_pct  = 0;
	int sink_idle_pct = 0;
	int stall_cycles  = 0;
	int hold_left     = 0;
	bit hold_req      = 1'b0;
	bit hold_ack      = 1'b0;

	hand_grab_pinch_event_tracker #(
		.MAX_HANDS(TABLE_DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #1 clk = ~clk;

	// Works out the result of one item and advances the predicted state.
	function automatic hgpet_out_t predict_hand_result(hgpet_in_t item);
		hgpet_out_t          res;
		int                  slot;
		int                  free_slot;
		logic                past_grab;
		logic                past_pinch;
		logic [FINGER_W-1:0] past_fingers;
		logic                grabbed;
		logic                pinched;
		res = '0;
		if (item.mode == MODE_FRAME) begin
			res.hand_count_changed = (item.hand_count != prev_hand_count);
			res.release_axes = res.hand_count_changed && (item.hand_count == '0);
			prev_hand_count = item.hand_count;
			return res;
		end
		slot = -1;
		free_slot = -1;
		past_grab = 1'b0;
		past_pinch = 1'b0;
		past_fingers = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (tracked_valid[i]) begin
				if (slot < 0 && tracked_id[i] == item.hand_id)
					slot = i;
			end else if (free_slot < 0) begin
				free_slot = i;
			end
		end
		if (slot >= 0) begin
			past_grab = tracked_grabbed[slot];
			past_pinch = tracked_pinched[slot];
			past_fingers = tracked_fingers[slot];
		end else if (free_slot >= 0) begin
			// A new id takes the first free entry and starts from a cleared state.
			slot = free_slot;
			tracked_valid[slot] = 1'b1;
			tracked_id[slot] = item.hand_id;
		end else begin
			res.table_full = 1'b1;
		end

		grabbed = (item.grab_strength >= grab_thr);
		res.grabbing = grabbed;
		if (grabbed && !past_grab)
			res.grab_edge = EDGE_PRESSED;
		else if (!grabbed && past_grab)
			res.grab_edge = EDGE_RELEASED;

		// While the hand is closed the pinch state is frozen and not reported.
		if (grabbed) begin
			pinched = past_pinch;
		end else begin
			pinched = (item.pinch_strength > pinch_thr);
			res.pinching = pinched;
			if (pinched && !past_pinch)
				res.pinch_edge = EDGE_PRESSED;
			else if (!pinched && past_pinch)
				res.pinch_edge = EDGE_RELEASED;
		end

		res.finger_count_changed = (item.finger_count != past_fingers);
		res.front_touch = ($signed(item.touch_distance) <= 0);
		res.side_left = item.hand_is_left;

		if (slot >= 0) begin
			tracked_grabbed[slot] = grabbed;
			tracked_pinched[slot] = pinched;
			tracked_fingers[slot] = item.finger_count;
		end
		return res;
	endfunction

	// Random content for the fields that an item's mode leaves unused.
	function automatic hgpet_in_t random_noise();
		logic [95:0] bits;
		bits = {$urandom, $urandom, $urandom};
		return bits[$bits(hgpet_in_t)-1:0];
	endfunction

	function automatic hgpet_in_t frame_item(logic [COUNT_W-1:0] count);
		hgpet_in_t item;
		item = random_noise();
		item.mode = MODE_FRAME;
		item.hand_count = count;
		return item;
	endfunction

	function automatic hgpet_in_t hand_item(logic [ID_W-1:0] id, logic left,
			logic [STRENGTH_W-1:0] grab, logic [STRENGTH_W-1:0] pinch,
			logic [FINGER_W-1:0] fingers, logic [TOUCH_W-1:0] touch);
		hgpet_in_t item;
		item = random_noise();
		item.mode = MODE_HAND;
		item.hand_id = id;
		item.hand_is_left = left;
		item.grab_strength = grab;
		item.pinch_strength = pinch;
		item.finger_count = fingers;
		item.touch_distance = touch;
		return item;
	endfunction

	// Strengths cluster around the threshold so that both sides of the compare
	// and the exact boundary come up often.
	function automatic logic [STRENGTH_W-1:0] pick_strength(logic [STRENGTH_W-1:0] level);
		case ($urandom_range(0, 9))
			0: return level;
			1: return (level == '0) ? level : level - 1'b1;
			2: return (level == '1) ? level : level + 1'b1;
			3: return '0;
			4: return STRENGTH_W'(1024);
			5: return STRENGTH_W'($urandom);
			default: return STRENGTH_W'($urandom_range(0, 1024));
		endcase
	endfunction

	// A hand observation mostly on a tracked id; a few use fresh ids or ids
	// one bit away from a tracked one, which find the table full.
	function automatic hgpet_in_t random_hand();
		int                  idx;
		int                  pick;
		logic [ID_W-1:0]     id;
		logic [FINGER_W-1:0] fingers;
		logic [TOUCH_W-1:0]  touch;
		idx = $urandom_range(0, TABLE_DEPTH - 1);
		id = tracked_id[idx];
		pick = $urandom_range(0, 99);
		if (pick < 6)
			id = $urandom;
		else if (pick < 10)
			id = id ^ (32'd1 << $urandom_range(0, ID_W - 1));
		fingers = $urandom_range(0, 1) ? tracked_fingers[idx] : FINGER_W'($urandom_range(0, 7));
		case ($urandom_range(0, 5))
			0: touch = '0;
			1: touch = '1;
			2: touch = TOUCH_W'(1);
			3: touch = TOUCH_W'($urandom);
			default: touch = TOUCH_W'($urandom_range(0, 2048) - 1024);
		endcase
		return hand_item(id, 1'($urandom_range(0, 1)), pick_strength(grab_thr),
			pick_strength(pinch_thr), fingers, touch);
	endfunction

	task automatic report_mismatch(string msg);
		if (error_count < MAX_PRINTED)
			$display("ERROR at %0t ns: %s", $time, msg);
		error_count++;
	endtask

	task automatic check_field(string name, logic [1:0] got, logic [1:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
	endtask

	// Offers one item and holds it until the transfer, then predicts its
	// result. The sender may idle afterwards; otherwise in_valid stays high
	// for the next item.
	task automatic send_item(hgpet_in_t item);
		int         gap;
		hgpet_out_t res;
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (!in_ready);
		res = predict_hand_result(item);
		expected_results.insert(expected_results.size(), res);
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(0, 99) < src_idle_pct)
			gap++;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stops offering items until every predicted result has arrived.
	task automatic wait_for_drain();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes both thresholds on consecutive cycles; the block must be idle.
	task automatic set_thresholds(logic [STRENGTH_W-1:0] grab_level,
			logic [STRENGTH_W-1:0] pinch_level);
		cfg_we <= 1'b1;
		cfg_index <= REG_GRAB_THRESHOLD;
		cfg_wdata <= grab_level;
		@(posedge clk);
		cfg_index <= REG_PINCH_THRESHOLD;
		cfg_wdata <= pinch_level;
		@(posedge clk);
		cfg_we <= 1'b0;
		grab_thr = grab_level;
		pinch_thr = pinch_level;
	endtask

	// Frame starts: no change from the reset count, a jump to the largest
	// count, a repeat, and drops to zero that release the axes.
	task automatic test_frame_counts();
		send_item(frame_item(4'd0));
		send_item(frame_item(4'd15));
		send_item(frame_item(4'd15));
		send_item(frame_item(4'd0));
		send_item(frame_item(4'd9));
		send_item(frame_item(4'd0));
	endtask

	// Eight new ids fill the table, covering the extremes of the id and the
	// touch distance; a ninth id then finds the table full, twice.
	task automatic test_table_fill();
		send_item(hand_item(32'h0000_0000, 1'b1, 11'd1024, 11'd2047, 3'd7, 12'h000));
		send_item(hand_item(32'hFFFF_FFFF, 1'b0, 11'd1023, 11'd820, 3'd0, 12'h800));
		send_item(hand_item(32'h8000_0000, 1'b1, 11'd0, 11'd819, 3'd3, 12'h7FF));
		send_item(hand_item(32'h7FFF_FFFF, 1'b0, 11'd2047, 11'd0, 3'd1, 12'hC00));
		send_item(hand_item(32'h0000_0001, 1'b1, 11'd0, 11'd1024, 3'd5, 12'h001));
		send_item(hand_item(32'hFFFF_FFFE, 1'b0, 11'd1024, 11'd1024, 3'd2, 12'hFFF));
		send_item(hand_item(32'h5A5A_5A5A, 1'b1, 11'd512, 11'd900, 3'd4, 12'h400));
		send_item(hand_item(32'hA5A5_A5A4, 1'b0, 11'd100, 11'd100, 3'd6, 12'h200));
		send_item(hand_item(32'h0000_0002, 1'b1, 11'd1024, 11'd0, 3'd4, 12'h000));
		send_item(hand_item(32'h0000_0002, 1'b0, 11'd1024, 11'd1000, 3'd4, 12'h010));
	endtask

	// Grab and pinch edges on tracked hands. The pinch pressed before a grab
	// stays stored while the hand is closed and is released once it opens.
	task automatic test_grab_pinch();
		send_item(hand_item(32'h0000_0000, 1'b1, 11'd0, 11'd1024, 3'd7, 12'h001));
		send_item(hand_item(32'h0000_0000, 1'b1, 11'd1024, 11'd0, 3'd6, 12'h001));
		send_item(hand_item(32'h0000_0000, 1'b1, 11'd1024, 11'd0, 3'd6, 12'h000));
		send_item(hand_item(32'h0000_0000, 1'b1, 11'd0, 11'd0, 3'd6, 12'h001));
		send_item(hand_item(32'hFFFF_FFFF, 1'b0, 11'd0, 11'd819, 3'd0, 12'h001));
	endtask

	// The receiver holds off for a long stretch while the sender keeps
	// offering, so the pipeline fills and in_ready falls. The sender then
	// waits for every result before going on.
	task automatic test_backpressure();
		int saved_pct;
		saved_pct = src_idle_pct;
		src_idle_pct = 0;
		hold_req <= ~hold_req;
		repeat (20)
			send_item(random_hand());
		wait_for_drain();
		src_idle_pct = saved_pct;
	endtask

	// Blocks of random traffic, each under its own threshold setting. Most
	// traffic is a frame start followed by that many observations; about one
	// pick in ten sends a stray observation outside that pattern instead.
	task automatic test_random_traffic(int first_block);
		int                 sent;
		logic [COUNT_W-1:0] count;
		for (int blk = first_block; blk < first_block + BLOCKS_PER_RUN; blk++) begin
			wait_for_drain();
			case (blk)
				0: set_thresholds(11'd1024, 11'd819);
				1: set_thresholds(11'd0, 11'd0);
				2: set_thresholds(11'd2047, 11'd2047);
				3: set_thresholds(11'd0, 11'd1024);
				4: set_thresholds(11'd1024, 11'd0);
				5: set_thresholds(11'd1024, 11'd1024);
				default: set_thresholds(STRENGTH_W'($urandom_range(0, 1024)),
					STRENGTH_W'($urandom_range(0, 1024)));
			endcase
			sent = 0;
			while (sent < BLOCK_ITEMS) begin
				if ($urandom_range(0, 9) == 0) begin
					send_item(random_hand());
					sent++;
				end else begin
					count = ($urandom_range(0, 7) == 0) ? COUNT_W'($urandom_range(0, 15))
						: COUNT_W'($urandom_range(0, 3));
					send_item(frame_item(count));
					sent++;
					repeat (count) begin
						send_item(random_hand());
						sent++;
					end
				end
			end
		end
	endtask

	// Receiver: random stalls, or a long hold-off on request.
	always @(posedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
		end
	end

	// Each output transfer is checked against the oldest prediction.
	always @(posedge clk) begin
		hgpet_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result transfer with no item pending");
			end else begin
				want = expected_results.pop_front();
				check_field("grabbing", out_data.grabbing, want.grabbing);
				check_field("grab_edge", out_data.grab_edge, want.grab_edge);
				check_field("pinching", out_data.pinching, want.pinching);
				check_field("pinch_edge", out_data.pinch_edge, want.pinch_edge);
				check_field("finger_count_changed", out_data.finger_count_changed,
					want.finger_count_changed);
				check_field("front_touch", out_data.front_touch, want.front_touch);
				check_field("side_left", out_data.side_left, want.side_left);
				check_field("hand_count_changed", out_data.hand_count_changed,
					want.hand_count_changed);
				check_field("release_axes", out_data.release_axes, want.release_axes);
				check_field("table_full", out_data.table_full, want.table_full);
			end
		end
	end

	// Cycles in a row with no transfer on either channel.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("ERROR: no transfer for %0d cycles", STALL_LIMIT);
		$display("hand_grab_pinch_event_tracker: mismatch");
		$finish;
	end

	initial begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			tracked_valid[i] = 1'b0;
			tracked_id[i] = '0;
			tracked_grabbed[i] = 1'b0;
			tracked_pinched[i] = 1'b0;
			tracked_fingers[i] = '0;
		end
		prev_hand_count = '0;
		grab_thr = GRAB_THRESHOLD_RST;
		pinch_thr = PINCH_THRESHOLD_RST;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// First profile: the sender rarely idles, the receiver often stalls.
		src_idle_pct = 6;
		sink_idle_pct = 47;
		test_frame_counts();
		test_table_fill();
		test_grab_pinch();
		test_backpressure();
		test_random_traffic(0);

		// Second profile: the roles swap.
		src_idle_pct = 47;
		sink_idle_pct = 6;
		test_random_traffic(BLOCKS_PER_RUN);

		// Third profile: full rate on both sides.
		src_idle_pct = 0;
		sink_idle_pct = 0;
		test_random_traffic(2 * BLOCKS_PER_RUN);

		wait_for_drain();
		if (error_count == 0)
			$display("hand_grab_pinch_event_tracker: match");
		else
			$display("hand_grab_pinch_event_tracker: mismatch");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/hgpet_pkg.sv
rtl/core/hgpet_table.sv
rtl/core/hgpet_eval.sv
rtl/core/hand_grab_pinch_event_tracker.sv
dv/tb.sv
